// ===== src/ddo_pkg.sv =====
// ----------------------------------------------------------------------------
// ddo_pkg
// Types, register map and constants shared by the odometry block.
// ----------------------------------------------------------------------------
`default_nettype none

package ddo_pkg;

   localparam int unsigned ADDR_W  = 5;
   localparam int unsigned DIV_W   = 52;
   localparam int unsigned CRD_W   = 50;
   localparam int unsigned ANG_W   = 34;

   localparam logic [2:0] REG_MPT    = 3'd0;
   localparam logic [2:0] REG_LGAIN  = 3'd1;
   localparam logic [2:0] REG_RGAIN  = 3'd2;
   localparam logic [2:0] REG_ITW    = 3'd3;
   localparam logic [2:0] REG_GLIMIT = 3'd4;

   localparam logic       OP_INTEGRATE = 1'b0;
   localparam logic       OP_SEED      = 1'b1;

   localparam logic [31:0] KINV_Q32   = 32'h9B74_EDA8;
   localparam logic [31:0] USEC_PER_S = 32'd1_000_000;
   localparam logic [30:0] MAX_S31    = 31'h7FFF_FFFF;
   localparam logic [17:0] GAIN_ONE   = 18'd65536;

   typedef struct packed {
      logic               opcode;
      logic signed [31:0] left_count;
      logic signed [31:0] right_count;
      logic               time_valid;
      logic [31:0]        timestamp_us;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [15:0] heading;
      logic [31:0]        travel_total;
      logic [31:0]        travel_left;
      logic [31:0]        travel_right;
      logic signed [31:0] speed;
      logic signed [31:0] yaw_rate;
      logic               glitch_seen;
      logic [15:0]        glitch_total;
   } rsp_type;

   function automatic logic [31:0] ddo_atan(input logic [4:0] idx);
      logic [31:0] v;
      begin
         unique case (idx)
            5'd0:  v = 32'h2000_0000;
            5'd1:  v = 32'h12E4_051E;
            5'd2:  v = 32'h09FB_385B;
            5'd3:  v = 32'h0511_11D4;
            5'd4:  v = 32'h028B_0D43;
            5'd5:  v = 32'h0145_D7E1;
            5'd6:  v = 32'h00A2_F61E;
            5'd7:  v = 32'h0051_7C55;
            5'd8:  v = 32'h0028_BE53;
            5'd9:  v = 32'h0014_5F2F;
            5'd10: v = 32'h000A_2F98;
            5'd11: v = 32'h0005_17CC;
            5'd12: v = 32'h0002_8BE6;
            5'd13: v = 32'h0001_45F3;
            5'd14: v = 32'h0000_A2FA;
            5'd15: v = 32'h0000_517D;
            5'd16: v = 32'h0000_28BE;
            5'd17: v = 32'h0000_145F;
            5'd18: v = 32'h0000_0A30;
            5'd19: v = 32'h0000_0518;
            5'd20: v = 32'h0000_028C;
            5'd21: v = 32'h0000_0146;
            5'd22: v = 32'h0000_00A3;
            5'd23: v = 32'h0000_0051;
            default: v = 32'h0;
         endcase
         return v;
      end
   endfunction

endpackage

`default_nettype wire

// ===== src/diff_drive_odometry_top.sv =====
// Seed and glitch words skip the datapath and go straight to the response; an
// integrate word runs the multiplier and CORDIC sequence and, when speed and yaw
// rate are recomputed, two passes of the shared divider (52 quotient steps each).
// Throughput: one word at a time; the shared multiplier, CORDIC and divider
// are sequenced per word. Reset clears pose, distances, rates and baseline.
// ----------------------------------------------------------------------------
// diff_drive_odometry_top
// Differential-drive wheel odometry with midpoint heading integration.
// ----------------------------------------------------------------------------
`default_nettype none

module diff_drive_odometry_top
   import ddo_pkg::*;
#(
   parameter int unsigned CORDIC_STEPS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire req_type           req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rsp_type                rsp_data,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   localparam logic [4:0] S_IDLE = 5'd0,  S_GCHK = 5'd1,  S_L0 = 5'd2,  S_L1 = 5'd3,
                          S_L2   = 5'd4,  S_L3   = 5'd5,  S_R1 = 5'd6,  S_R2 = 5'd7,
                          S_R3   = 5'd8,  S_CM   = 5'd9,  S_PD = 5'd10, S_KX = 5'd11,
                          S_KI   = 5'd12, S_CW   = 5'd13, S_PU = 5'd14, S_SP0 = 5'd15,
                          S_SP1  = 5'd16, S_SPW  = 5'd17, S_YW0 = 5'd18, S_YW1 = 5'd19,
                          S_YWW  = 5'd20, S_TU   = 5'd21, S_RESP = 5'd22;

   logic [4:0]  state_ff, state_in;

   logic [31:0] mpt_ff, itw_ff;
   logic [17:0] lgain_ff, rgain_ff;
   logic [30:0] glimit_ff;

   req_type     item_ff;
   logic [31:0] prev_l_ff, prev_r_ff, x_acc_ff, y_acc_ff;
   logic [31:0] dist_c_ff, dist_l_ff, dist_r_ff, speed_ff, yaw_ff, prev_t_ff;
   logic [15:0] heading_ff, gcount_ff;
   logic        base_ff, ptv_ff, gseen_ff;

   logic [31:0] mag_l_ff, mag_r_ff, dmag_ff, cmag_ff, dh_ff, ang_ff;
   logic        neg_l_ff, neg_r_ff, dneg_ff, cneg_ff, flip_ff;
   logic [15:0] hi_ff;
   logic [33:0] acc_ff;
   logic signed [31:0] lm_ff, rm_ff;

   logic [31:0] mul_a, mul_b;
   logic [63:0] prod_ff;

   logic                    div_start, div_busy;
   logic [DIV_W-1:0]        div_dvd;
   logic [30:0]             div_q;
   logic                    crd_start, crd_busy;
   logic signed [CRD_W-1:0] crd_x0, crd_x, crd_y, xr, yr;

   logic        wr_en;
   logic [31:0] base_l, base_r, dl, dr, ml, mr;
   logic        glitch;
   logic [50:0] scaled;
   logic [30:0] s31;
   logic signed [31:0] sgn_s;
   logic signed [32:0] sum_lr, diff_lr, cm33;
   logic [31:0] half, half_s;
   logic [15:0] dh16;
   logic [31:0] ang_raw;
   logic        flip;
   logic [46:0] x0_mag;
   logic        rate_ok;
   logic [31:0] dt;
   logic [31:0] rate_v;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      begin
         s = {1'b0, a} + {1'b0, b};
         return s[32] ? 32'hFFFF_FFFF : s[31:0];
      end
   endfunction

   ddo_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod_ff)
   );

   ddo_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (dt),
      .busy_ff  (div_busy),
      .quot_sat (div_q)
   );

   ddo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (crd_start),
      .x_start (crd_x0),
      .angle   (ang_ff),
      .busy_ff (crd_busy),
      .x_ff    (crd_x),
      .y_ff    (crd_y)
   );

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      unique case (paddr[4:2])
         REG_MPT:    prdata = mpt_ff;
         REG_LGAIN:  prdata = 32'(lgain_ff);
         REG_RGAIN:  prdata = 32'(rgain_ff);
         REG_ITW:    prdata = itw_ff;
         REG_GLIMIT: prdata = 32'(glimit_ff);
         default:    prdata = '0;
      endcase
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = state_ff == S_RESP;

   assign base_l = base_ff ? prev_l_ff : '0;
   assign base_r = base_ff ? prev_r_ff : '0;
   assign dl     = item_ff.left_count - base_l;
   assign dr     = item_ff.right_count - base_r;
   assign ml     = dl[31] ? -dl : dl;
   assign mr     = dr[31] ? -dr : dr;
   assign glitch = (glimit_ff != '0) && ((ml > 32'(glimit_ff)) || (mr > 32'(glimit_ff)));

   assign scaled = {1'b0, prod_ff[33:0], 16'b0} + 51'(acc_ff);
   assign s31    = (|scaled[50:31]) ? MAX_S31 : scaled[30:0];

   always_comb begin
      sgn_s = signed'({1'b0, s31});
      if ((state_ff == S_L3) ? neg_l_ff : neg_r_ff) begin
         sgn_s = -sgn_s;
      end
   end

   assign sum_lr  = 33'(lm_ff) + 33'(rm_ff);
   assign diff_lr = 33'(rm_ff) - 33'(lm_ff);
   assign cm33    = (sum_lr + signed'(33'(sum_lr[32]))) >>> 1;

   assign half    = prod_ff[48:17];
   assign half_s  = dneg_ff ? -half : half;
   assign dh16    = dneg_ff ? -prod_ff[47:32] : prod_ff[47:32];
   assign ang_raw = {heading_ff, 16'b0} + half_s;
   assign flip    = ang_raw[31] ^ ang_raw[30];

   assign x0_mag  = prod_ff[62:16];
   assign crd_x0  = cneg_ff ? -CRD_W'(x0_mag) : CRD_W'(x0_mag);
   assign crd_start = state_ff == S_KI;

   assign xr = flip_ff ? -crd_x : crd_x;
   assign yr = flip_ff ? -crd_y : crd_y;

   assign rate_ok = item_ff.time_valid && ptv_ff && (item_ff.timestamp_us > prev_t_ff);
   assign dt      = item_ff.timestamp_us - prev_t_ff;
   assign div_dvd = prod_ff[DIV_W-1:0];
   assign div_start = (state_ff == S_SP1) || (state_ff == S_YW1);

   always_comb begin
      rate_v = {1'b0, div_q};
      if ((state_ff == S_SPW) ? cneg_ff : dneg_ff) begin
         rate_v = -rate_v;
      end
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_L0: begin
            mul_a = mag_l_ff;
            mul_b = mpt_ff;
         end
         S_L1: begin
            mul_a = prod_ff[47:16];
            mul_b = 32'(lgain_ff);
         end
         S_L2: begin
            mul_a = 32'(hi_ff);
            mul_b = 32'(lgain_ff);
         end
         S_L3: begin
            mul_a = mag_r_ff;
            mul_b = mpt_ff;
         end
         S_R1: begin
            mul_a = prod_ff[47:16];
            mul_b = 32'(rgain_ff);
         end
         S_R2: begin
            mul_a = 32'(hi_ff);
            mul_b = 32'(rgain_ff);
         end
         S_PD: begin
            mul_a = dmag_ff;
            mul_b = itw_ff;
         end
         S_KX: begin
            mul_a = cmag_ff;
            mul_b = KINV_Q32;
         end
         S_SP0: begin
            mul_a = cmag_ff;
            mul_b = USEC_PER_S;
         end
         S_YW0: begin
            mul_a = dh_ff;
            mul_b = USEC_PER_S;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid) state_in = S_GCHK;
         S_GCHK: begin
            if (item_ff.opcode == OP_SEED || glitch) begin
               state_in = S_RESP;
            end else begin
               state_in = S_L0;
            end
         end
         S_L0:  state_in = S_L1;
         S_L1:  state_in = S_L2;
         S_L2:  state_in = S_L3;
         S_L3:  state_in = S_R1;
         S_R1:  state_in = S_R2;
         S_R2:  state_in = S_R3;
         S_R3:  state_in = S_CM;
         S_CM:  state_in = S_PD;
         S_PD:  state_in = S_KX;
         S_KX:  state_in = S_KI;
         S_KI:  state_in = S_CW;
         S_CW:  if (!crd_busy) state_in = S_PU;
         S_PU:  state_in = rate_ok ? S_SP0 : S_TU;
         S_SP0: state_in = S_SP1;
         S_SP1: state_in = S_SPW;
         S_SPW: if (!div_busy) state_in = S_YW0;
         S_YW0: state_in = S_YW1;
         S_YW1: state_in = S_YWW;
         S_YWW: if (!div_busy) state_in = S_TU;
         S_TU:  state_in = S_RESP;
         S_RESP: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         mpt_ff     <= '0;
         lgain_ff   <= GAIN_ONE;
         rgain_ff   <= GAIN_ONE;
         itw_ff     <= '0;
         glimit_ff  <= '0;
         prev_l_ff  <= '0;
         prev_r_ff  <= '0;
         base_ff    <= 1'b0;
         x_acc_ff   <= '0;
         y_acc_ff   <= '0;
         heading_ff <= '0;
         dist_c_ff  <= '0;
         dist_l_ff  <= '0;
         dist_r_ff  <= '0;
         speed_ff   <= '0;
         yaw_ff     <= '0;
         prev_t_ff  <= '0;
         ptv_ff     <= 1'b0;
         gcount_ff  <= '0;
         gseen_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (wr_en) begin
            unique case (paddr[4:2])
               REG_MPT:    mpt_ff    <= pwdata;
               REG_LGAIN:  lgain_ff  <= pwdata[17:0];
               REG_RGAIN:  rgain_ff  <= pwdata[17:0];
               REG_ITW:    itw_ff    <= pwdata;
               REG_GLIMIT: glimit_ff <= pwdata[30:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            S_GCHK: begin
               prev_l_ff <= item_ff.left_count;
               prev_r_ff <= item_ff.right_count;
               base_ff   <= 1'b1;
               gseen_ff  <= 1'b0;
               if (item_ff.opcode == OP_INTEGRATE && glitch) begin
                  gseen_ff <= 1'b1;
                  if (gcount_ff != 16'hFFFF) begin
                     gcount_ff <= gcount_ff + 1'b1;
                  end
                  ptv_ff    <= item_ff.time_valid;
                  prev_t_ff <= item_ff.time_valid ? item_ff.timestamp_us : '0;
               end
            end
            S_KX: heading_ff <= heading_ff + dh16;
            S_PU: begin
               x_acc_ff  <= x_acc_ff + xr[47:16];
               y_acc_ff  <= y_acc_ff + yr[47:16];
               dist_c_ff <= sat_add(dist_c_ff, cmag_ff);
               dist_l_ff <= sat_add(dist_l_ff, lm_ff[31] ? -lm_ff : lm_ff);
               dist_r_ff <= sat_add(dist_r_ff, rm_ff[31] ? -rm_ff : rm_ff);
            end
            S_SPW: if (!div_busy) speed_ff <= rate_v;
            S_YWW: if (!div_busy) yaw_ff <= rate_v;
            S_TU: begin
               ptv_ff    <= item_ff.time_valid;
               prev_t_ff <= item_ff.time_valid ? item_ff.timestamp_us : '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         item_ff <= req_data;
      end
      unique case (state_ff) inside
         S_GCHK: begin
            mag_l_ff <= ml;
            mag_r_ff <= mr;
            neg_l_ff <= dl[31];
            neg_r_ff <= dr[31];
         end
         S_L1, S_R1: hi_ff <= prod_ff[63:48];
         S_L2, S_R2: acc_ff <= prod_ff[49:16];
         S_L3: lm_ff <= sgn_s;
         S_R3: rm_ff <= sgn_s;
         S_CM: begin
            cneg_ff <= cm33[32];
            cmag_ff <= cm33[32] ? 32'(-cm33) : cm33[31:0];
            dneg_ff <= diff_lr[32];
            dmag_ff <= diff_lr[32] ? 32'(-diff_lr) : diff_lr[31:0];
         end
         S_KX: begin
            dh_ff   <= prod_ff[63:32];
            flip_ff <= flip;
            ang_ff  <= {ang_raw[31] ^ flip, ang_raw[30:0]};
         end
         default: ;
      endcase
   end

   assign rsp_data.pos_x        = x_acc_ff;
   assign rsp_data.pos_y        = y_acc_ff;
   assign rsp_data.heading      = heading_ff;
   assign rsp_data.travel_total = dist_c_ff;
   assign rsp_data.travel_left  = dist_l_ff;
   assign rsp_data.travel_right = dist_r_ff;
   assign rsp_data.speed        = speed_ff;
   assign rsp_data.yaw_rate     = yaw_ff;
   assign rsp_data.glitch_seen  = gseen_ff;
   assign rsp_data.glitch_total = gcount_ff;

endmodule

`default_nettype wire

// ===== src/ddo_mul.sv =====
// ----------------------------------------------------------------------------
// ddo_mul
// Shared 32x32 unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_mul (
   input  wire logic        clock,
   input  wire logic [31:0] op_a,
   input  wire logic [31:0] op_b,
   output logic [63:0]      prod_ff
);

   logic [63:0] prod_in;

   assign prod_in = 64'(op_a) * 64'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

// ===== src/ddo_div.sv =====
// ----------------------------------------------------------------------------
// ddo_div
// Restoring divider, one quotient bit per cycle, saturated 31-bit quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_div
   import ddo_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DIV_W-1:0] dividend,
   input  wire logic [31:0]      divisor,
   output logic                  busy_ff,
   output logic [30:0]           quot_sat
);

   localparam int unsigned CNT_W = $clog2(DIV_W);

   logic [DIV_W-1:0] dvd_ff, dvd_in;
   logic [31:0]      rem_ff, rem_in;
   logic [31:0]      dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_in;
   logic [32:0]      trial;
   logic             fits;

   assign trial = {rem_ff, dvd_ff[DIV_W-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CNT_W'(DIV_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? 32'(trial - {1'b0, dsr_ff}) : trial[31:0];
         dvd_in = {dvd_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign quot_sat = (|dvd_ff[DIV_W-1:31]) ? MAX_S31 : dvd_ff[30:0];

endmodule

`default_nettype wire

// ===== src/ddo_cordic.sv =====
// ----------------------------------------------------------------------------
// ddo_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_cordic
   import ddo_pkg::*;
#(
   parameter int unsigned STEPS = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic signed [CRD_W-1:0] x_start,
   input  wire logic [31:0]             angle,
   output logic                         busy_ff,
   output logic signed [CRD_W-1:0]     x_ff,
   output logic signed [CRD_W-1:0]     y_ff
);

   localparam int unsigned CNT_W = $clog2(STEPS + 1);

   logic signed [CRD_W-1:0] x_in, y_in, xs, ys;
   logic signed [ANG_W-1:0] z_ff, z_in, at;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    busy_in;

   assign xs = x_ff >>> cnt_ff;
   assign ys = y_ff >>> cnt_ff;
   assign at = ANG_W'(ddo_atan(5'(cnt_ff)));

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         x_in    = x_start;
         y_in    = '0;
         z_in    = ANG_W'(signed'(angle));
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[ANG_W-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      cnt_ff <= cnt_in;
   end

endmodule

`default_nettype wire

// ===== src/ddo_checker.sv =====
// ----------------------------------------------------------------------------
// ddo_checker
// Port-level checks for the odometry block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_checker
   import ddo_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word accepted while busy");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("ready while result pending");

   a_glitch_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.glitch_seen |-> rsp_data.glitch_total != 16'd0)
      else $error("glitch flagged with zero count");

endmodule

bind diff_drive_odometry_top ddo_checker u_ddo_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
